FILE: sv/bounded_double_ended_queue_macros.svh
// Assertion macros shared by the double-ended queue modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDEQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BDEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bdeq_pkg.sv
// Package for the bounded double-ended queue: operation and status codes,
// payload structs and the command/status structs between controller and datapath.
// No dependencies.
package bdeq_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int WORD_W        = 32;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_DUMP       = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]               op;
        logic signed [WORD_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] word;
        logic                     last;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;        // capture the incoming item
        logic       push;        // write the word, move pointers, report ok
        logic       pop;         // read the word, move pointers
        logic       dump_start;  // read the front word
        logic       dump_next;   // read the word after the current one
        logic       report;      // emit a status-only result
        logic [1:0] code;        // status code for a report
        logic       emit_data;   // emit the word read in the previous cycle
        logic       emit_last;   // last mark for emit_data
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] op;
        logic       empty;
        logic       full;
        logic       dump_last;
    } dp_stat_t;

endpackage

FILE: sv/bdeq_datapath.sv
// Datapath of the double-ended queue: slot memory, front pointer, occupancy,
// dump walk counter and the result register. Depends on bdeq_pkg and the macros header.
`include "bounded_double_ended_queue_macros.svh"

module bdeq_datapath #(
    parameter int DEPTH = bdeq_pkg::DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bdeq_pkg::in_item_t   item,
    input  bdeq_pkg::dp_cmd_t    cmd,
    output bdeq_pkg::dp_stat_t   stat,
    output logic                 done,
    output bdeq_pkg::out_item_t  result
);
    import bdeq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W:0]   DEPTH_S = (IDX_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    logic signed [WORD_W-1:0] slots [DEPTH];

    in_item_t                 item_reg;
    logic [IDX_W-1:0]         front_reg, front_next;
    logic [CNT_W-1:0]         occ_reg, occ_next;
    logic [IDX_W-1:0]         k_reg, k_next;
    logic signed [WORD_W-1:0] rd_data_reg;
    logic                     done_reg, done_next;
    out_item_t                result_reg, result_next;

    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] occ_low;
    logic [IDX_W-1:0] occ_less_one;
    logic [CNT_W-1:0] occ_m1;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;

    // Offset from the front, wrapped around the ring.
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] ofs);
        logic [IDX_W:0] s;
        s = {1'b0, base} + {1'b0, ofs};
        if (s >= DEPTH_S)
        begin
            s = s - DEPTH_S;
        end
        return s[IDX_W-1:0];
    endfunction

    assign occ_m1       = occ_reg - CNT_W'(1);
    assign occ_low      = occ_reg[IDX_W-1:0];
    assign occ_less_one = occ_m1[IDX_W-1:0];
    assign front_dec    = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - IDX_W'(1);

    assign stat.op        = item_reg.op;
    assign stat.empty     = (occ_reg == '0);
    assign stat.full      = (occ_reg == DEPTH_C);
    assign stat.dump_last = ((CNT_W'(k_reg) + CNT_W'(1)) == occ_reg);

    always_comb
    begin
        front_next  = front_reg;
        occ_next    = occ_reg;
        k_next      = k_reg;
        wr_en       = 1'b0;
        wr_addr     = front_dec;
        rd_en       = 1'b0;
        rd_addr     = front_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        if (cmd.push)
        begin
            wr_en = 1'b1;
            if (item_reg.op == OP_PUSH_FRONT)
            begin
                wr_addr    = front_dec;
                front_next = front_dec;
            end
            else
            begin
                wr_addr = wrap_add(front_reg, occ_low);
            end
            occ_next    = occ_reg + CNT_W'(1);
            done_next   = 1'b1;
            result_next = '{status: ST_OK, word: '0, last: 1'b1};
        end

        if (cmd.pop)
        begin
            rd_en = 1'b1;
            if (item_reg.op == OP_POP_FRONT)
            begin
                rd_addr    = front_reg;
                front_next = wrap_add(front_reg, IDX_W'(1));
            end
            else
            begin
                rd_addr = wrap_add(front_reg, occ_less_one);
            end
            occ_next = occ_m1;
        end

        if (cmd.dump_start)
        begin
            rd_en   = 1'b1;
            rd_addr = front_reg;
            k_next  = '0;
        end

        if (cmd.dump_next)
        begin
            rd_en   = 1'b1;
            k_next  = k_reg + IDX_W'(1);
            rd_addr = wrap_add(front_reg, k_next);
        end

        if (cmd.report)
        begin
            done_next   = 1'b1;
            result_next = '{status: cmd.code, word: '0, last: 1'b1};
        end

        if (cmd.emit_data)
        begin
            done_next   = 1'b1;
            result_next = '{status: ST_OK, word: rd_data_reg, last: cmd.emit_last};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots[wr_addr] <= item_reg.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= slots[rd_addr];
        end
        if (cmd.load)
        begin
            item_reg <= item;
        end
        k_reg      <= k_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `BDEQ_ASSERT_SAME(a_occ_bound, 1'b1, occ_reg <= DEPTH_C, "occupancy above depth")
    `BDEQ_ASSERT_NEXT(a_push_grows, cmd.push, occ_reg == $past(occ_reg) + CNT_W'(1), "push did not grow queue")
    `BDEQ_ASSERT_SAME(a_full_report, cmd.report && cmd.code == ST_FULL, stat.full, "full reported on non-full queue")
    `BDEQ_ASSERT_NEXT(a_dump_cont, done_reg && !result_reg.last, done_reg, "dump stream broke before last")

endmodule

FILE: sv/bdeq_ctrl.sv
// Controller of the double-ended queue: accepts an operation, decides it
// against the queue status and sequences the datapath. Depends on bdeq_pkg and the macros header.
`include "bounded_double_ended_queue_macros.svh"

module bdeq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  bdeq_pkg::dp_stat_t stat,
    output bdeq_pkg::dp_cmd_t  cmd
);
    import bdeq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_POP  = 4'b0100,
        S_DUMP = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_IDLE;
                case (stat.op) inside
                    OP_PUSH_FRONT, OP_PUSH_BACK:
                    begin
                        if (stat.full)
                        begin
                            cmd.report = 1'b1;
                            cmd.code   = ST_FULL;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK:
                    begin
                        if (stat.empty)
                        begin
                            cmd.report = 1'b1;
                            cmd.code   = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.pop    = 1'b1;
                            state_next = S_POP;
                        end
                    end
                    OP_DUMP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.report = 1'b1;
                            cmd.code   = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.dump_start = 1'b1;
                            state_next     = S_DUMP;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_POP:
            begin
                cmd.emit_data = 1'b1;
                cmd.emit_last = 1'b1;
                state_next    = S_IDLE;
            end

            S_DUMP:
            begin
                // One stored word leaves per cycle while the next one is read.
                cmd.emit_data = 1'b1;
                cmd.emit_last = stat.dump_last;
                if (stat.dump_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.dump_next = 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `BDEQ_ASSERT_NEXT(a_load_exec, cmd.load, state_reg == S_EXEC, "accepted item not executed")
    `BDEQ_ASSERT_SAME(a_emit_state, cmd.emit_data, state_reg == S_POP || state_reg == S_DUMP, "data emitted outside read states")
    `BDEQ_ASSERT_NEXT(a_pop_emit, cmd.pop, cmd.emit_data && cmd.emit_last, "pop result not emitted")

endmodule

FILE: sv/bounded_double_ended_queue.sv
// Bounded double-ended queue of signed words in a ring buffer.
// Push and status-only results go from the execute state into the result register; pops and
// the first dumped word pass the registered memory read first, then one dumped word per cycle.
// Busy covers the execute state, plus the pop state for pops or the dump walk for a dump,
// set by the registered memory read and the controller's walk. Results cannot be stalled.
// Reset clears the pointers and occupancy (empty queue); slot contents are not cleared.
module bounded_double_ended_queue #(
    parameter int DEPTH = bdeq_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bdeq_pkg::in_item_t  item,
    output logic                done,
    output bdeq_pkg::out_item_t result
);
    import bdeq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bdeq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    bdeq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule

FILE: sim/tb_bounded_double_ended_queue.sv
`timescale 1ns / 100ps
// Self-checking testbench for bounded_double_ended_queue: directed table, then random bursts.
// Depends on bdeq_pkg and the bounded_double_ended_queue RTL.
module tb_bounded_double_ended_queue;
    import bdeq_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = DEPTH + 8;
    localparam int PHASE_ITEMS  = 70;
    localparam int SHOWN_FAULTS = 10;

    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] value;
        logic        typed;
        logic [1:0]  status;
    } script_row_t;

    localparam int SCRIPT_LEN = 22;

    // Rows marked typed carry a status-only result with word zero and last set.
    script_row_t script [0:SCRIPT_LEN-1] = '{
        '{OP_POP_FRONT,  32'h0000_0000, 1'b1, ST_EMPTY},
        '{OP_POP_BACK,   32'hFFFF_FFFF, 1'b1, ST_EMPTY},
        '{OP_DUMP,       32'h0000_0000, 1'b1, ST_EMPTY},
        '{OP_SPARE_LO,   32'hFFFF_FFFF, 1'b0, ST_OK},
        '{OP_SPARE_MID,  32'h0000_0000, 1'b0, ST_OK},
        '{OP_SPARE_HI,   32'hFFFF_FFFF, 1'b0, ST_OK},
        '{OP_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, ST_OK},
        '{OP_PUSH_BACK,  32'h8000_0000, 1'b1, ST_OK},
        '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, ST_OK},
        '{OP_PUSH_BACK,  32'h0000_0000, 1'b1, ST_OK},
        '{OP_DUMP,       32'h0000_0000, 1'b0, ST_OK},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK},
        '{OP_POP_BACK,   32'h0000_0000, 1'b0, ST_OK},
        '{OP_DUMP,       32'h0000_0000, 1'b0, ST_OK},
        '{OP_POP_BACK,   32'h0000_0000, 1'b0, ST_OK},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b1, ST_EMPTY},
        '{OP_PUSH_BACK,  32'h5555_5555, 1'b1, ST_OK},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK},
        '{OP_PUSH_FRONT, 32'hAAAA_AAAA, 1'b1, ST_OK},
        '{OP_POP_BACK,   32'h0000_0000, 1'b0, ST_OK},
        '{OP_DUMP,       32'h0000_0000, 1'b1, ST_EMPTY}
    };

    logic      clk = 1'b0;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  item;
    logic      done;
    out_item_t result;

    // Shadow copy of the ring buffer.
    logic signed [WORD_W-1:0] shadow_slots [DEPTH];
    int unsigned              shadow_front;
    int unsigned              shadow_count;

    out_item_t step_results [$];
    out_item_t awaited [$];
    int        fault_count;
    int        cycles;
    int        idle_pct;

    bounded_double_ended_queue #(.DEPTH(DEPTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("bounded_double_ended_queue verification failed");
            $finish;
        end
    end

    function automatic void note_fault(input string what, input out_item_t want,
                                       input out_item_t got);
        fault_count++;
        if (fault_count <= SHOWN_FAULTS)
            $display("%0t: %s: expected status %0d word %0d last %0b, got status %0d word %0d last %0b",
                     $realtime, what, want.status, want.word, want.last,
                     got.status, got.word, got.last);
    endfunction

    // Applies one operation to the shadow queue and collects the results it causes.
    function automatic void deque_apply(input in_item_t it);
        out_item_t   r;
        int unsigned slot;
        int unsigned k;
        step_results.delete();
        r = '0;
        r.last = 1'b1;
        case (it.op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (shadow_count == DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    if (it.op == OP_PUSH_FRONT)
                    begin
                        shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                        shadow_slots[shadow_front] = it.value;
                    end
                    else
                        shadow_slots[(shadow_front + shadow_count) % DEPTH] = it.value;
                    shadow_count++;
                    r.status = ST_OK;
                end
                step_results.push_back(r);
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    if (it.op == OP_POP_FRONT)
                    begin
                        slot = shadow_front;
                        shadow_front = (shadow_front + 1) % DEPTH;
                    end
                    else
                        slot = (shadow_front + shadow_count - 1) % DEPTH;
                    shadow_count--;
                    r.status = ST_OK;
                    r.word = shadow_slots[slot];
                end
                step_results.push_back(r);
            end
            OP_DUMP:
            begin
                if (shadow_count == 0)
                begin
                    r.status = ST_EMPTY;
                    step_results.push_back(r);
                end
                else
                    for (k = 0; k < shadow_count; k++)
                    begin
                        r.status = ST_OK;
                        r.word = shadow_slots[(shadow_front + k) % DEPTH];
                        r.last = (k + 1 == shadow_count);
                        step_results.push_back(r);
                    end
            end
            default: ;
        endcase
    endfunction

    // Holds the item on the inputs until the block takes the transfer.
    task automatic issue(input logic [2:0] op, input logic [31:0] value,
                         input logic typed, input logic [1:0] typed_status);
        in_item_t  it;
        out_item_t want;
        it.op = op;
        it.value = value;
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        deque_apply(it);
        if (typed)
        begin
            want = '0;
            want.status = typed_status;
            want.last = 1'b1;
            awaited.push_back(want);
        end
        else
            foreach (step_results[i])
                awaited.push_back(step_results[i]);
    endtask

    task automatic sender_gap();
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic drain_pause();
        start <= 1'b0;
        @(posedge clk);
        while (awaited.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && done)
        begin
            if (awaited.size() == 0)
            begin
                want = '0;
                note_fault("result with nothing awaited", want, result);
            end
            else
            begin
                want = awaited.pop_front();
                if (result.status !== want.status || result.word !== want.word
                    || result.last !== want.last)
                    note_fault("result mismatch", want, result);
            end
        end
    end

    initial
    begin : stimulus
        int counted;
        int burst;
        int extra;
        logic [2:0] op;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        fault_count = 0;
        cycles = 0;
        shadow_front = 0;
        shadow_count = 0;
        idle_pct = 12;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            issue(script[i].op, script[i].value, script[i].typed, script[i].status);
            sender_gap();
        end
        drain_pause();

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 12 : (phase == 1) ? 47 : 0;
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                case ($urandom_range(3))
                    0:
                    begin
                        // Fill to the limit, push into a full queue, then dump it all.
                        while (shadow_count < DEPTH)
                        begin
                            op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                            issue(op, pick_word(), 1'b0, ST_OK);
                            sender_gap();
                            counted++;
                        end
                        extra = $urandom_range(1, 2);
                        repeat (extra)
                        begin
                            op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                            issue(op, pick_word(), 1'b0, ST_OK);
                            sender_gap();
                            counted++;
                        end
                        issue(OP_DUMP, $urandom, 1'b0, ST_OK);
                        sender_gap();
                        counted++;
                    end
                    1:
                    begin
                        while (shadow_count > 0)
                        begin
                            op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
                            issue(op, $urandom, 1'b0, ST_OK);
                            sender_gap();
                            counted++;
                        end
                        op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
                        issue(op, $urandom, 1'b0, ST_OK);
                        sender_gap();
                        counted++;
                    end
                    default:
                    begin
                        burst = $urandom_range(4, 10);
                        repeat (burst)
                        begin
                            case ($urandom_range(9))
                                0, 1: op = OP_PUSH_FRONT;
                                2, 3: op = OP_PUSH_BACK;
                                4, 5: op = OP_POP_FRONT;
                                6, 7: op = OP_POP_BACK;
                                8: op = OP_DUMP;
                                default: op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                            endcase
                            issue(op, pick_word(), 1'b0, ST_OK);
                            sender_gap();
                            if (op <= OP_DUMP)
                                counted++;
                        end
                    end
                endcase
            end
            // Let the block go quiet before the next phase.
            drain_pause();
        end

        while (awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
        if (fault_count == 0)
            $display("bounded_double_ended_queue verification clean");
        else
            $display("bounded_double_ended_queue verification failed");
        $finish;
    end
endmodule

FILE: bounded_double_ended_queue.f
+incdir+sv
sv/bdeq_pkg.sv
sv/bdeq_datapath.sv
sv/bdeq_ctrl.sv
sv/bounded_double_ended_queue.sv
sim/tb_bounded_double_ended_queue.sv
